/* hdl/ftoc_pkg.sv */
// Shared types, constants and the digit step for the frame time offset check.
package ftoc_pkg;

    // Field widths
    localparam int SyncW   = 32;
    localparam int TcW     = 32;
    localparam int HourW   = 5;
    localparam int MinW    = 6;
    localparam int SecW    = 6;
    localparam int DiffW   = 18;
    localparam int DayW    = 10;
    localparam int FsecW   = 17;
    localparam int ThrW    = 16;
    localparam int SodW    = 17;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 32;

    // Time constants
    localparam int SecPerDay  = 86400;
    localparam int SecPerHour = 3600;
    localparam int SecPerMin  = 60;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegMidnightThr = 2'd0;
    localparam logic [CfgIdxW-1:0] RegExpectedSync = 2'd1;
    localparam logic [CfgIdxW-1:0] RegCheckSync = 2'd2;

    // Register reset values
    localparam logic [ThrW-1:0]  MidnightThrRst  = 16'd60;
    localparam logic [SyncW-1:0] ExpectedSyncRst = 32'hABAD_DEED;
    localparam logic             CheckSyncRst    = 1'b1;

    // Status codes
    localparam logic StatusOk       = 1'b0;
    localparam logic StatusMisalign = 1'b1;

    typedef struct packed {
        logic [ThrW-1:0]  midnight_threshold;
        logic [SyncW-1:0] expected_sync;
        logic             check_sync;
    } cfg_t;

    // Running decimal value of a hex numeral, and whether reading stopped
    typedef struct packed {
        logic             stop;
        logic [FsecW-1:0] acc;
    } dec_t;

    // Take one nibble as a decimal digit; stop at the first nibble above nine.
    // Leading zero nibbles keep the value at zero, so they need no special case.
    function automatic dec_t bcd_step(dec_t cur, logic [3:0] nib);
        dec_t r;
        r = cur;
        if (!cur.stop)
        begin
            if (nib > 4'd9)
            begin
                r.stop = 1'b1;
            end
            else
            begin
                r.acc = FsecW'(cur.acc * FsecW'(10) + FsecW'(nib));
            end
        end
        return r;
    endfunction

endpackage

/* hdl/ftoc_if.sv */
// Valid/ready channel interfaces for frame header items and check results.
interface ftoc_in_if import ftoc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SyncW-1:0] sync_word;
    logic [TcW-1:0]   timecode_word;
    logic [HourW-1:0] ref_hour;
    logic [MinW-1:0]  ref_minute;
    logic [SecW-1:0]  ref_second;

    modport source (output valid, sync_word, timecode_word, ref_hour, ref_minute,
                    ref_second, input ready);
    modport sink (input valid, sync_word, timecode_word, ref_hour, ref_minute,
                  ref_second, output ready);
endinterface

interface ftoc_out_if import ftoc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DiffW-1:0] second_diff;
    logic                    status;
    logic [DayW-1:0]         frame_day;
    logic [FsecW-1:0]        frame_second;

    modport source (output valid, second_diff, status, frame_day, frame_second,
                    input ready);
    modport sink (input valid, second_diff, status, frame_day, frame_second,
                  output ready);
endinterface

/* hdl/ftoc_cfg_regs.sv */
// Configuration registers written through the plain write port.
module ftoc_cfg_regs import ftoc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata,
    output cfg_t               cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; ignore unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.midnight_threshold <= MidnightThrRst;
            cfg_reg.expected_sync      <= ExpectedSyncRst;
            cfg_reg.check_sync         <= CheckSyncRst;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegMidnightThr:  cfg_reg.midnight_threshold <= cfg_wdata[ThrW-1:0];
                RegExpectedSync: cfg_reg.expected_sync      <= cfg_wdata[SyncW-1:0];
                RegCheckSync:    cfg_reg.check_sync         <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/frame_time_offset_check.sv */
// Top level: three-stage pipeline checking frame sync and time against a reference.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        sync_word, timecode_word, ref_hour/minute/second
//  out_ch    out  valid/ready        second_diff, status, frame_day, frame_second
//  cfg       in   cfg_we (no ready)  cfg_index, cfg_wdata
//
// One item enters per cycle while out_ch back-pressure leaves room in the stages;
// its result is valid once it is in the stage 3 register. Stage 1 compares sync,
// decodes the day and the upper seconds digits and forms the reference second of
// day; stage 2 finishes the seconds digits and sets the reference window flags;
// stage 3 applies the midnight correction and is the output register.
// Reset clears all valid bits and loads register defaults.
// A stage holds its item while the stage after it is full and not moving.
module frame_time_offset_check import ftoc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    ftoc_in_if.sink            in_ch,
    ftoc_out_if.source         out_ch,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [CfgW-1:0]    cfg_wdata
);

    localparam logic [DiffW-1:0] Day18 = DiffW'(SecPerDay);

    cfg_t cfg;

    ftoc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Stage registers
    logic             s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic             s1_mis_reg, s2_mis_reg, s3_mis_reg;
    logic [DayW-1:0]  s1_day_reg, s2_day_reg, s3_day_reg;
    dec_t             s1_sec_reg;
    logic [7:0]       s1_sec_lo_reg;
    logic [SodW-1:0]  s1_sod_reg, s2_sod_reg;
    logic [FsecW-1:0] s2_m5_reg, s3_m5_reg;
    logic             s2_late_reg, s2_early_reg;
    logic [DiffW-1:0] s3_diff_reg;

    // Stage enables
    logic rdy1, rdy2, rdy3;
    assign rdy3 = !s3_valid_reg || out_ch.ready;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign in_ch.ready = rdy1;

    // Stage 1: sync compare, day decode, upper seconds digits, reference second of day
    logic             s1_mis_next;
    dec_t             day_d0, day_d1, day_d2;
    dec_t             sec_d0, sec_d1, s1_sec_next;
    logic [SodW-1:0]  s1_sod_next;

    always_comb
    begin
        s1_mis_next = cfg.check_sync && (in_ch.sync_word != cfg.expected_sync);
        day_d0 = bcd_step('0, in_ch.timecode_word[31:28]);
        day_d1 = bcd_step(day_d0, in_ch.timecode_word[27:24]);
        day_d2 = bcd_step(day_d1, in_ch.timecode_word[23:20]);
        sec_d0 = bcd_step('0, in_ch.timecode_word[19:16]);
        sec_d1 = bcd_step(sec_d0, in_ch.timecode_word[15:12]);
        s1_sec_next = bcd_step(sec_d1, in_ch.timecode_word[11:8]);
        s1_sod_next = SodW'(in_ch.ref_hour * SodW'(SecPerHour))
                    + SodW'(in_ch.ref_minute * SodW'(SecPerMin))
                    + SodW'(in_ch.ref_second);
    end

    // Stage 2: last seconds digits and reference window flags
    dec_t             sec_d3, sec_d4;
    logic [DiffW-1:0] day_minus_thr;
    logic             s2_late_next, s2_early_next;

    always_comb
    begin
        sec_d3 = bcd_step(s1_sec_reg, s1_sec_lo_reg[7:4]);
        sec_d4 = bcd_step(sec_d3, s1_sec_lo_reg[3:0]);
        day_minus_thr = Day18 - DiffW'(cfg.midnight_threshold);
        s2_late_next  = DiffW'(s1_sod_reg) > day_minus_thr;
        s2_early_next = DiffW'(s1_sod_reg) < DiffW'(cfg.midnight_threshold);
    end

    // Stage 3: midnight correction
    logic             wrap_late, wrap_early;
    logic [DiffW-1:0] base_diff, s3_diff_next;

    always_comb
    begin
        wrap_late  = s2_late_reg && (DiffW'(s2_m5_reg) < DiffW'(cfg.midnight_threshold));
        wrap_early = s2_early_reg && (DiffW'(s2_m5_reg) > day_minus_thr);
        base_diff  = DiffW'(s2_sod_reg) - DiffW'(s2_m5_reg);
        if (wrap_late)
        begin
            s3_diff_next = base_diff - Day18;
        end
        else if (wrap_early)
        begin
            s3_diff_next = base_diff + Day18;
        end
        else
        begin
            s3_diff_next = base_diff;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= in_ch.valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_mis_reg    <= s1_mis_next;
            s1_day_reg    <= day_d2.acc[DayW-1:0];
            s1_sec_reg    <= s1_sec_next;
            s1_sec_lo_reg <= in_ch.timecode_word[7:0];
            s1_sod_reg    <= s1_sod_next;
        end
        if (rdy2)
        begin
            s2_mis_reg   <= s1_mis_reg;
            s2_day_reg   <= s1_day_reg;
            s2_m5_reg    <= sec_d4.acc;
            s2_sod_reg   <= s1_sod_reg;
            s2_late_reg  <= s2_late_next;
            s2_early_reg <= s2_early_next;
        end
        if (rdy3)
        begin
            s3_mis_reg  <= s2_mis_reg;
            s3_day_reg  <= s2_day_reg;
            s3_m5_reg   <= s2_m5_reg;
            s3_diff_reg <= s3_diff_next;
        end
    end

    // Drive results; zero the fields on a misaligned frame
    assign out_ch.valid        = s3_valid_reg;
    assign out_ch.status       = s3_mis_reg ? StatusMisalign : StatusOk;
    assign out_ch.second_diff  = s3_mis_reg ? '0 : $signed(s3_diff_reg);
    assign out_ch.frame_day    = s3_mis_reg ? '0 : s3_day_reg;
    assign out_ch.frame_second = s3_mis_reg ? '0 : s3_m5_reg;

    // Checks
    a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> s1_valid_reg)
        else $error("accepted item did not reach stage 1");

    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !rdy3 |=> s2_valid_reg && $stable(s2_m5_reg))
        else $error("stage 2 item lost during stall");

    a_mis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_mis_reg |-> out_ch.second_diff == '0 && out_ch.frame_day == '0
        && out_ch.frame_second == '0)
        else $error("misaligned result carries nonzero fields");

    a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> s2_m5_reg < FsecW'(100000))
        else $error("decoded seconds out of range");

    a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_day_reg < DayW'(1000))
        else $error("decoded day out of range");

endmodule
